### hdl/pts_pkg.sv
// Shared types, constants, microcode program and helpers for the trajectory sampler.
`timescale 1ns / 1ps

package pts_pkg;

	// Table geometry.
	localparam int SEGMENTS = 16;
	localparam int COEFFS   = 8;
	localparam int AXES     = 3;

	localparam int SEG_W     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW        = $clog2(COEFFS);
	localparam int WT_MAX    = ((COEFFS - 1) * (COEFFS - 2) > (COEFFS - 1)) ?
		(COEFFS - 1) * (COEFFS - 2) : (COEFFS - 1);
	localparam int WT_W      = $clog2(WT_MAX + 1);
	localparam int AW        = SEG_W + 2 + CW;
	localparam int RAM_DEPTH = 1 << AW;

	// Number formats.
	localparam int C_W    = 48;
	localparam int T_W    = 32;
	localparam int FRAC   = 24;
	localparam int DIG_W  = 24;
	localparam int PROD_W = 96;
	localparam int Q_W    = PROD_W - FRAC;
	localparam int U_W    = 52;
	localparam int ACC_W  = 64;
	localparam int TERM_W = U_W + WT_W + 1;

	localparam logic [C_W-1:0] P_ONE = C_W'(1) << FRAC;
	localparam logic [C_W-1:0] P_CAP = '1;
	localparam logic [50:0]    T_LIM = 51'd1 << 50;

	// Input opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Result kinds; also the power offset of a term (position, velocity, acceleration).
	localparam logic [1:0] KIND_POS = 2'd0;
	localparam logic [1:0] KIND_VEL = 2'd1;
	localparam logic [1:0] KIND_ACC = 2'd2;

	localparam logic [1:0] AX_LAST = 2'(AXES - 1);
	localparam logic [CW-1:0] J_LAST = CW'(COEFFS - 1);

	// Micro-operations.
	localparam logic [1:0] UOP_NOP  = 2'd0;
	localparam logic [1:0] UOP_POW  = 2'd1;
	localparam logic [1:0] UOP_TERM = 2'd2;
	localparam logic [1:0] UOP_DONE = 2'd3;

	// Sequencing conditions.
	localparam logic [1:0] JMP_NEXT  = 2'd0;
	localparam logic [1:0] JMP_JLOOP = 2'd1;
	localparam logic [1:0] JMP_ALOOP = 2'd2;
	localparam logic [1:0] JMP_HOME  = 2'd3;

	localparam int PC_W   = 5;
	localparam int UC_LEN = 18;

	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_POW  = 5'd1;
	localparam logic [PC_W-1:0] PC_TERM = 5'd7;
	localparam logic [PC_W-1:0] PC_DONE = 5'd17;

	typedef struct packed {
		logic [1:0]      uop;
		logic [1:0]      dlt;
		logic [1:0]      cond;
		logic [PC_W-1:0] tgt;
	} pts_uword_t;

	// Control word that travels down the arithmetic pipeline with each operation.
	typedef struct packed {
		logic            vld;
		logic            pow;
		logic [1:0]      kind;
		logic [1:0]      axis;
		logic [CW-1:0]   j;
		logic [CW-1:0]   pidx;
		logic [WT_W-1:0] weight;
	} pts_ctl_t;

	typedef struct packed {
		logic                  opcode;
		logic [3:0]            segment;
		logic [1:0]            axis;
		logic [2:0]            power_index;
		logic signed [C_W-1:0] coefficient;
		logic [T_W-1:0]        local_time;
	} pts_cmd_t;

	typedef struct packed {
		logic signed [C_W-1:0] pos_x;
		logic signed [C_W-1:0] pos_y;
		logic signed [C_W-1:0] pos_z;
		logic signed [C_W-1:0] vel_x;
		logic signed [C_W-1:0] vel_y;
		logic signed [C_W-1:0] vel_z;
		logic signed [C_W-1:0] acc_x;
		logic signed [C_W-1:0] acc_y;
		logic signed [C_W-1:0] acc_z;
	} pts_res_t;

	// Derivative weight of coefficient j for a term kind; zero means the term is skipped.
	function automatic logic [WT_W-1:0] pts_weight(input logic [CW-1:0] j, input logic [1:0] d);
		logic [2*CW-1:0] p;
		p = (2*CW)'(j) * (2*CW)'(j - CW'(1));
		case (d)
			KIND_POS: pts_weight = WT_W'(1);
			KIND_VEL: pts_weight = WT_W'(j);
			KIND_ACC: pts_weight = WT_W'(p);
			default:  pts_weight = '0;
		endcase
	endfunction

	// Program: power loop, then per axis three terms per coefficient, then drain and finish.
	localparam pts_uword_t UCODE [UC_LEN] = '{
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_POW,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_JLOOP, tgt: PC_POW},
		'{uop: UOP_TERM, dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_TERM, dlt: KIND_VEL, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_TERM, dlt: KIND_ACC, cond: JMP_JLOOP, tgt: PC_TERM},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_ALOOP, tgt: PC_TERM},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_NOP,  dlt: KIND_POS, cond: JMP_NEXT,  tgt: PC_IDLE},
		'{uop: UOP_DONE, dlt: KIND_POS, cond: JMP_HOME,  tgt: PC_IDLE}
	};

endpackage

### hdl/poly_trajectory_sampler_unit.sv
// Top level: piecewise polynomial trajectory sampler with microcoded evaluation.
// A load item leaves busy low and causes no result.
// An evaluate item keeps busy high while the microcode program runs on the single shared
// multiply pipeline; the result strobe follows in the cycle after the last program step.
// An evaluate of a segment beyond the table gives an all-zero result.
// Reset clears the sequencer and pipeline control; the coefficient RAM is not cleared.
`timescale 1ns / 1ps

module poly_trajectory_sampler_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pts_pkg::pts_cmd_t cmd,
	output logic              done,
	output pts_pkg::pts_res_t result
);
	import pts_pkg::*;

	logic           accept, acc_ev, go_eval, go_zero, seg_ok, pi_ok, fin;
	logic [8:0]     seg_ext;
	logic [4:0]     pi_ext;
	logic [SEG_W-1:0] seg_q;
	logic [T_W-1:0] t_q;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [C_W-1:0] ram_rdata;
	pts_ctl_t       ctl;

	// Item acceptance and range checks.
	assign accept  = start && !busy;
	assign seg_ext = 9'(cmd.segment);
	assign pi_ext  = 5'(cmd.power_index);
	assign seg_ok  = (seg_ext < 9'(SEGMENTS));
	assign pi_ok   = (pi_ext < 5'(COEFFS));
	assign acc_ev  = accept && (cmd.opcode == OP_EVAL);
	assign go_eval = acc_ev && seg_ok;
	assign go_zero = acc_ev && !seg_ok;

	// Segment and time are held for the whole evaluation.
	always_ff @(posedge clk) begin
		if (acc_ev) begin
			seg_q <= seg_ext[SEG_W-1:0];
			t_q   <= cmd.local_time;
		end
	end

	// Coefficient store port: loads while idle, program reads while busy.
	assign ram_we   = accept && (cmd.opcode == OP_LOAD) && seg_ok &&
		(cmd.axis < 2'(AXES)) && pi_ok;
	assign ram_addr = busy ? {seg_q, ctl.axis, ctl.j} :
		{seg_ext[SEG_W-1:0], cmd.axis, pi_ext[CW-1:0]};

	pts_ram #(
		.WIDTH(C_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cmd.coefficient),
		.rdata(ram_rdata)
	);

	pts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go_eval(go_eval),
		.go_zero(go_zero),
		.ctl    (ctl),
		.fin    (fin),
		.busy   (busy)
	);

	pts_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (acc_ev),
		.fin       (fin),
		.ctl       (ctl),
		.coef_rd   (ram_rdata),
		.local_time(t_q),
		.result    (result),
		.done      (done)
	);

`ifndef SYNTHESIS
	// A result only follows the last step of a busy program.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a finished program");

	// A load item never causes a result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.opcode == OP_LOAD)) |=> !done)
		else $error("result strobe after a load item");

	// An evaluate item always starts the sequencer.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.opcode == OP_EVAL)) |=> busy)
		else $error("evaluate item did not start the program");

	// The store is never written while the program reads it.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy)
		else $error("coefficient write during evaluation");
`endif

endmodule

### hdl/pts_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module pts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable; read data is registered every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### hdl/pts_seq.sv
// Microcode sequencer: step counter, loop counters and decode of the control word.
`timescale 1ns / 1ps

module pts_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go_eval,
	input  logic              go_zero,
	output pts_pkg::pts_ctl_t ctl,
	output logic              fin,
	output logic              busy
);
	import pts_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [CW-1:0]   jc_q;
	logic [1:0]      ax_q;
	pts_uword_t      uw;
	logic [WT_W-1:0] wt;

	assign uw = UCODE[pc_q];
	assign wt = pts_weight(jc_q, uw.dlt);

	// Decode the current control word into one pipeline operation.
	always_comb begin
		ctl.pow    = (uw.uop == UOP_POW);
		ctl.vld    = ctl.pow || ((uw.uop == UOP_TERM) && (wt != '0));
		ctl.kind   = uw.dlt;
		ctl.axis   = ax_q;
		ctl.j      = jc_q;
		ctl.pidx   = ctl.pow ? (jc_q - CW'(1)) : (jc_q - CW'(uw.dlt));
		ctl.weight = wt;
	end

	assign fin  = (uw.uop == UOP_DONE);
	assign busy = (pc_q != PC_IDLE);

	// Step counter with loop counters for coefficient index and axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			jc_q <= '0;
			ax_q <= '0;
		end else if (pc_q == PC_IDLE) begin
			if (go_eval) begin
				pc_q <= PC_POW;
				jc_q <= CW'(1);
				ax_q <= '0;
			end else if (go_zero) begin
				pc_q <= PC_DONE;
			end
		end else begin
			unique case (uw.cond)
				JMP_NEXT: begin
					pc_q <= pc_q + PC_W'(1);
				end
				JMP_JLOOP: begin
					if (jc_q != J_LAST) begin
						jc_q <= jc_q + CW'(1);
						pc_q <= uw.tgt;
					end else begin
						jc_q <= '0;
						pc_q <= pc_q + PC_W'(1);
					end
				end
				JMP_ALOOP: begin
					if (ax_q != AX_LAST) begin
						ax_q <= ax_q + 2'd1;
						pc_q <= uw.tgt;
					end else begin
						pc_q <= pc_q + PC_W'(1);
					end
				end
				JMP_HOME: begin
					pc_q <= PC_IDLE;
				end
				default: begin
					pc_q <= PC_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/pts_mac.sv
// Datapath: power table, split 48x48 multiply, clamp, weighting and nine accumulators.
`timescale 1ns / 1ps

module pts_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          fin,
	input  pts_pkg::pts_ctl_t             ctl,
	input  logic [pts_pkg::C_W-1:0]       coef_rd,
	input  logic [pts_pkg::T_W-1:0]       local_time,
	output pts_pkg::pts_res_t             result,
	output logic                          done
);
	import pts_pkg::*;

	logic [C_W-1:0]           pow_q [COEFFS];
	pts_ctl_t                 ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [C_W-1:0]           pw_s1;
	logic [C_W-1:0]           mag_s2, opb_s2;
	logic                     neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2*DIG_W-1:0]       pp_s3 [4];
	logic [2*DIG_W:0]         lo_s4, mid_s4;
	logic [2*DIG_W-1:0]       hi_s4;
	logic [PROD_W-1:0]        prod_s5;
	logic signed [U_W-1:0]    u_s6;
	logic signed [TERM_W-1:0] term_s7;
	logic signed [ACC_W-1:0]  acc_q [3][3];
	logic [Q_W-1:0]           q;
	logic                     t_over;
	logic [50:0]              qc;
	logic signed [WT_W:0]     wt;
	logic                     done_q;
	pts_res_t                 res_q;

	// Saturate a sum to the signed 48-bit range.
	function automatic logic [C_W-1:0] sat48(input logic signed [ACC_W-1:0] a);
		if ((a[ACC_W-1:C_W-1] == '0) || (a[ACC_W-1:C_W-1] == '1)) begin
			sat48 = a[C_W-1:0];
		end else if (a[ACC_W-1]) begin
			sat48 = {1'b1, {(C_W-1){1'b0}}};
		end else begin
			sat48 = {1'b0, {(C_W-1){1'b1}}};
		end
	endfunction

	// Scaled product and its clamp for the coefficient path.
	assign q      = prod_s5[PROD_W-1:FRAC];
	assign t_over = (|q[Q_W-1:51]) || (q[50] && (|q[49:0]));
	assign qc     = t_over ? T_LIM : q[50:0];
	assign wt     = {1'b0, ctl_s6.weight};

	// Control words move down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			done_q <= fin;
		end
	end

	// Operand fetch, magnitude, partial products, product assembly, sign and weighting.
	always_ff @(posedge clk) begin
		pw_s1 <= (ctl.pidx == '0) ? P_ONE : pow_q[ctl.pidx];

		if (ctl_s1.pow) begin
			mag_s2 <= pw_s1;
			opb_s2 <= C_W'(local_time);
			neg_s2 <= 1'b0;
		end else begin
			mag_s2 <= coef_rd[C_W-1] ? (~coef_rd + C_W'(1)) : coef_rd;
			opb_s2 <= pw_s1;
			neg_s2 <= coef_rd[C_W-1];
		end

		pp_s3[0] <= (2*DIG_W)'(mag_s2[DIG_W-1:0]) * (2*DIG_W)'(opb_s2[DIG_W-1:0]);
		pp_s3[1] <= (2*DIG_W)'(mag_s2[DIG_W-1:0]) * (2*DIG_W)'(opb_s2[C_W-1:DIG_W]);
		pp_s3[2] <= (2*DIG_W)'(mag_s2[C_W-1:DIG_W]) * (2*DIG_W)'(opb_s2[DIG_W-1:0]);
		pp_s3[3] <= (2*DIG_W)'(mag_s2[C_W-1:DIG_W]) * (2*DIG_W)'(opb_s2[C_W-1:DIG_W]);
		neg_s3   <= neg_s2;

		// Negative values get a bias so the shift rounds toward minus infinity.
		lo_s4  <= (2*DIG_W+1)'(pp_s3[0]) +
			(neg_s3 ? (2*DIG_W+1)'((1 << FRAC) - 1) : '0);
		mid_s4 <= (2*DIG_W+1)'(pp_s3[1]) + (2*DIG_W+1)'(pp_s3[2]);
		hi_s4  <= pp_s3[3];
		neg_s4 <= neg_s3;

		prod_s5 <= PROD_W'(lo_s4) + (PROD_W'(mid_s4) << DIG_W) +
			(PROD_W'(hi_s4) << (2*DIG_W));
		neg_s5  <= neg_s4;

		u_s6 <= neg_s5 ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

		term_s7 <= TERM_W'(u_s6) * TERM_W'(wt);
	end

	// Power table: each new power of t lands here from the product stage.
	always_ff @(posedge clk) begin
		if (ctl_s5.vld && ctl_s5.pow) begin
			pow_q[ctl_s5.j] <= (|q[Q_W-1:C_W]) ? P_CAP : q[C_W-1:0];
		end
	end

	// Nine running sums, cleared when an evaluate item is taken.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int a = 0; a < 3; a++) begin
				if (clear) begin
					acc_q[k][a] <= '0;
				end else if (ctl_s7.vld && !ctl_s7.pow && (ctl_s7.kind == 2'(k)) &&
						(ctl_s7.axis == 2'(a))) begin
					acc_q[k][a] <= acc_q[k][a] + ACC_W'(term_s7);
				end
			end
		end
	end

	// Result register loaded on the final program step.
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.pos_x <= sat48(acc_q[KIND_POS][0]);
			res_q.pos_y <= sat48(acc_q[KIND_POS][1]);
			res_q.pos_z <= sat48(acc_q[KIND_POS][2]);
			res_q.vel_x <= sat48(acc_q[KIND_VEL][0]);
			res_q.vel_y <= sat48(acc_q[KIND_VEL][1]);
			res_q.vel_z <= sat48(acc_q[KIND_VEL][2]);
			res_q.acc_x <= sat48(acc_q[KIND_ACC][0]);
			res_q.acc_y <= sat48(acc_q[KIND_ACC][1]);
			res_q.acc_z <= sat48(acc_q[KIND_ACC][2]);
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule
